>>> hdl/sdspi_pkg.sv
// Package for the SD card SPI-mode init and block read sequencer.
// Holds beat types, sequencer state type, phase and command codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sdspi_pkg;

   localparam logic [1:0] OP_INIT = 2'd0;
   localparam logic [1:0] OP_READ = 2'd1;
   localparam logic [1:0] OP_BYTE = 2'd2;

   localparam logic [3:0] PH_IDLE      = 4'd0;
   localparam logic [3:0] PH_WAKE      = 4'd1;
   localparam logic [3:0] PH_CMD_SEND  = 4'd2;
   localparam logic [3:0] PH_CMD_POLL  = 4'd3;
   localparam logic [3:0] PH_CMD_TRAIL = 4'd4;
   localparam logic [3:0] PH_GAP       = 4'd5;
   localparam logic [3:0] PH_TOKEN     = 4'd6;
   localparam logic [3:0] PH_DATA      = 4'd7;
   localparam logic [3:0] PH_SKIP      = 4'd8;

   localparam logic [7:0] CMD_IDLE   = 8'h40;
   localparam logic [7:0] CMD_OPCOND = 8'h41;
   localparam logic [7:0] CMD_BLKLEN = 8'h50;
   localparam logic [7:0] CMD_READ   = 8'h51;
   localparam logic [7:0] CMD_CRC    = 8'h7B;

   localparam logic [7:0] BYTE_IDLE  = 8'hFF;
   localparam logic [7:0] DATA_TOKEN = 8'hFE;
   localparam logic [7:0] FRAME_CRC  = 8'h95;

   localparam logic [8:0] WAKE_BYTES = 9'd10;
   localparam logic [8:0] GAP_BYTES  = 9'd2;
   localparam logic [8:0] SKIP_BYTES = 9'd3;
   localparam logic [8:0] FRAME_LAST = 9'd5;

   typedef struct packed {
      logic [1:0]  op;
      logic [23:0] block_number;
      logic [8:0]  buffer_offset;
      logic [7:0]  rx_byte;
   } sdspi_req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        chip_select;
      logic        store_valid;
      logic [8:0]  store_address;
      logic [7:0]  store_byte;
      logic [7:0]  card_response;
      logic        done_res;
      logic        status;
      logic        fast_clock;
   } sdspi_rsp_type;

   typedef struct packed {
      logic [3:0]  phase;
      logic [8:0]  byte_count;
      logic [7:0]  command_code;
      logic [31:0] command_argument;
      logic [8:0]  base_offset;
      logic        select_level;
      logic        clock_fast_flag;
      logic [7:0]  last_reply;
   } sdspi_state_type;

endpackage

`default_nettype wire

>>> hdl/sdspi_step.sv
// Next-state and result logic of the SD SPI sequencer for one beat.
// Depends on sdspi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdspi_step
   import sdspi_pkg::*;
#(
   parameter int unsigned BLOCK_BYTES = 256
) (
   input  wire sdspi_req_type   req,
   input  wire sdspi_state_type cur,
   output sdspi_state_type      nxt,
   output logic                 emit,
   output sdspi_rsp_type        rsp
);

   localparam logic [8:0]  DATA_LAST  = 9'(BLOCK_BYTES - 1);
   localparam logic [31:0] BLOCK_ARG  = 32'(BLOCK_BYTES);

   logic        do_start;
   logic [7:0]  st_code;
   logic [31:0] st_arg;

   always_comb begin
      nxt      = cur;
      emit     = 1'b0;
      rsp      = '0;
      do_start = 1'b0;
      st_code  = CMD_IDLE;
      st_arg   = '0;

      if (req.op == OP_INIT || req.op == OP_READ) begin
         if (cur.phase == PH_IDLE) begin
            emit = 1'b1;
            if (req.op == OP_INIT) begin
               nxt.select_level = 1'b0;
               nxt.phase        = PH_WAKE;
               nxt.byte_count   = 9'd1;
               rsp.tx_valid     = 1'b1;
               rsp.tx_byte      = BYTE_IDLE;
            end else begin
               nxt.base_offset = req.buffer_offset;
               do_start        = 1'b1;
               st_code         = CMD_READ;
               st_arg          = {req.block_number, 8'd0};
            end
         end
      end else if (req.op == OP_BYTE) begin
         emit = 1'b1;
         unique case (cur.phase)
            PH_WAKE: begin
               if (cur.byte_count < WAKE_BYTES) begin
                  nxt.byte_count = cur.byte_count + 9'd1;
                  rsp.tx_valid   = 1'b1;
                  rsp.tx_byte    = BYTE_IDLE;
               end else begin
                  do_start = 1'b1;
                  st_code  = CMD_IDLE;
               end
            end
            PH_CMD_SEND: begin
               rsp.tx_valid = 1'b1;
               if (cur.byte_count <= FRAME_LAST) begin
                  unique case (cur.byte_count)
                     9'd1:    rsp.tx_byte = cur.command_argument[31:24];
                     9'd2:    rsp.tx_byte = cur.command_argument[23:16];
                     9'd3:    rsp.tx_byte = cur.command_argument[15:8];
                     9'd4:    rsp.tx_byte = cur.command_argument[7:0];
                     default: rsp.tx_byte = FRAME_CRC;
                  endcase
                  nxt.byte_count = cur.byte_count + 9'd1;
               end else begin
                  nxt.phase   = PH_CMD_POLL;
                  rsp.tx_byte = BYTE_IDLE;
               end
            end
            PH_CMD_POLL: begin
               if (req.rx_byte != BYTE_IDLE) begin
                  nxt.last_reply = req.rx_byte;
                  nxt.phase      = PH_CMD_TRAIL;
               end
               rsp.tx_valid = 1'b1;
               rsp.tx_byte  = BYTE_IDLE;
            end
            PH_CMD_TRAIL: begin
               nxt.select_level = 1'b1;
               unique case (cur.command_code)
                  CMD_IDLE: begin
                     if (cur.last_reply == 8'd1) begin
                        nxt.phase      = PH_GAP;
                        nxt.byte_count = 9'd1;
                        rsp.tx_valid   = 1'b1;
                        rsp.tx_byte    = BYTE_IDLE;
                     end else begin
                        do_start = 1'b1;
                        st_code  = CMD_IDLE;
                     end
                  end
                  CMD_OPCOND: begin
                     do_start = 1'b1;
                     st_code  = (cur.last_reply != 8'd0) ? CMD_OPCOND : CMD_CRC;
                  end
                  CMD_CRC: begin
                     do_start = 1'b1;
                     st_code  = CMD_BLKLEN;
                     st_arg   = BLOCK_ARG;
                  end
                  CMD_BLKLEN: begin
                     nxt.clock_fast_flag = 1'b1;
                     nxt.phase           = PH_IDLE;
                     rsp.done_res        = 1'b1;
                  end
                  CMD_READ: begin
                     if (cur.last_reply != 8'd0) begin
                        nxt.phase    = PH_IDLE;
                        rsp.done_res = 1'b1;
                        rsp.status   = 1'b1;
                     end else begin
                        nxt.select_level = 1'b0;
                        nxt.phase        = PH_TOKEN;
                        rsp.tx_valid     = 1'b1;
                        rsp.tx_byte      = BYTE_IDLE;
                     end
                  end
                  default: begin
                     nxt.phase    = PH_IDLE;
                     rsp.done_res = 1'b1;
                  end
               endcase
            end
            PH_GAP: begin
               if (cur.byte_count < GAP_BYTES) begin
                  nxt.byte_count = cur.byte_count + 9'd1;
                  rsp.tx_valid   = 1'b1;
                  rsp.tx_byte    = BYTE_IDLE;
               end else begin
                  do_start = 1'b1;
                  st_code  = CMD_OPCOND;
               end
            end
            PH_TOKEN: begin
               if (req.rx_byte == DATA_TOKEN) begin
                  nxt.phase      = PH_DATA;
                  nxt.byte_count = 9'd0;
               end
               rsp.tx_valid = 1'b1;
               rsp.tx_byte  = BYTE_IDLE;
            end
            PH_DATA: begin
               rsp.store_valid   = 1'b1;
               rsp.store_address = cur.base_offset + cur.byte_count;
               rsp.store_byte    = req.rx_byte;
               if (cur.byte_count >= DATA_LAST) begin
                  nxt.phase      = PH_SKIP;
                  nxt.byte_count = 9'd1;
               end else begin
                  nxt.byte_count = cur.byte_count + 9'd1;
               end
               rsp.tx_valid = 1'b1;
               rsp.tx_byte  = BYTE_IDLE;
            end
            PH_SKIP: begin
               if (cur.byte_count < SKIP_BYTES) begin
                  nxt.byte_count = cur.byte_count + 9'd1;
                  rsp.tx_valid   = 1'b1;
                  rsp.tx_byte    = BYTE_IDLE;
               end else begin
                  nxt.select_level = 1'b1;
                  nxt.phase        = PH_IDLE;
                  rsp.done_res     = 1'b1;
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end

      if (do_start) begin
         nxt.command_code     = st_code;
         nxt.command_argument = st_arg;
         nxt.select_level     = 1'b0;
         nxt.byte_count       = 9'd1;
         nxt.phase            = PH_CMD_SEND;
         rsp.tx_valid         = 1'b1;
         rsp.tx_byte          = st_code;
      end

      if (emit) begin
         rsp.chip_select   = nxt.select_level;
         rsp.card_response = nxt.last_reply;
         rsp.fast_clock    = nxt.clock_fast_flag;
      end
   end

endmodule

`default_nettype wire

>>> hdl/sd_spi_init_and_block_read_core.sv
// Top level of the SD card SPI-mode init and single block read sequencer.
// Depends on sdspi_pkg and sdspi_step.
//
//   channel  direction  handshake              beat
//   req_     in         req_valid / req_stall  sdspi_req_type
//   rsp_     out        rsp_valid / rsp_stall  sdspi_rsp_type
//
// One beat is decided per clock while req_stall is low; its result is
// registered in the output register, or in the skid one when that is held.
// Results sit in an output register backed by a one-beat skid register;
// req_stall rises only while the skid register is full.
// Synchronous active-high reset returns the sequencer to idle, deselected.
`timescale 1ns / 1ps
`default_nettype none

module sd_spi_init_and_block_read_core
   import sdspi_pkg::*;
#(
   parameter int unsigned BLOCK_BYTES = 256
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire sdspi_req_type req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output sdspi_rsp_type      rsp_data
);

   sdspi_state_type state_ff, state_in, step_state;
   sdspi_rsp_type   step_rsp;
   logic            step_emit;

   sdspi_rsp_type   out_ff, out_in, skid_ff, skid_in;
   logic            out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic            accept, push, pop;

   sdspi_step #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_step (
      .req  (req_data),
      .cur  (state_ff),
      .nxt  (step_state),
      .emit (step_emit),
      .rsp  (step_rsp)
   );

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign push      = accept && step_emit;
   assign pop       = out_valid_ff && !rsp_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      state_in = accept ? step_state : state_ff;
   end

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_in       = step_rsp;
            skid_valid_in = push;
         end else begin
            out_in       = step_rsp;
            out_valid_in = push;
         end
      end else if (!out_valid_ff) begin
         out_in       = step_rsp;
         out_valid_in = push;
      end else if (push) begin
         skid_in       = step_rsp;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase            <= PH_IDLE;
         state_ff.byte_count       <= '0;
         state_ff.command_code     <= '0;
         state_ff.command_argument <= '0;
         state_ff.base_offset      <= '0;
         state_ff.select_level     <= 1'b1;
         state_ff.clock_fast_flag  <= 1'b0;
         state_ff.last_reply       <= '0;
         out_valid_ff              <= 1'b0;
         skid_valid_ff             <= 1'b0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   a_store_sends_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.store_valid |-> rsp_data.tx_valid)
      else $error("data beat without a byte to transmit");

   a_done_deselects: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.chip_select && !rsp_data.tx_valid)
      else $error("finished sequence left card selected or sending");

   a_fast_sticks: assert property (@(posedge clock) disable iff (reset)
      state_ff.clock_fast_flag |=> state_ff.clock_fast_flag)
      else $error("fast clock flag dropped without reset");
`endif

endmodule

`default_nettype wire
